[hw/rtl/aep_pkg.sv]
// Package for the actuator elevation positioner: widths, reset values, codes,
// the arccos rotation angle table and the serial arithmetic request types.
// No dependencies.
`default_nettype none

package aep_pkg;

  localparam int SENSOR_BITS       = 10;
  localparam int ARCCOS_ITERATIONS = 16;
  localparam int SampleW           = 10;
  localparam int AddrW             = 5;

  localparam logic [15:0] RstArmA   = 16'd4000;
  localparam logic [15:0] RstArmB   = 16'd4000;
  localparam logic [15:0] RstBase   = 16'd3600;
  localparam logic [15:0] RstSpan   = 16'd2200;
  localparam logic [15:0] RstOffset = 16'd0;
  localparam logic [15:0] RstLower  = 16'd1000;
  localparam logic [15:0] RstUpper  = 16'd8000;

  typedef enum logic [2:0] {
    REG_ARM_A  = 3'd0,
    REG_ARM_B  = 3'd1,
    REG_BASE   = 3'd2,
    REG_SPAN   = 3'd3,
    REG_OFFSET = 3'd4,
    REG_LOWER  = 3'd5,
    REG_UPPER  = 3'd6,
    REG_ENABLE = 3'd7
  } reg_idx_e;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic          start;
    alu_op_e       op;
    logic [31:0]   opa;
    logic [31:0]   opb;
    logic [63:0]   dvd;
    logic [33:0]   dvs;
    logic [33:0]   rem0;
    logic [5:0]    steps;
  } alu_req_t;

  typedef struct packed {
    logic          done;
    logic [63:0]   prod;
    logic [31:0]   quo;
  } alu_rsp_t;

  // atan(2^-i) in degrees * 100 * 65536
  function automatic logic [31:0] atan_val(input logic [4:0] idx);
    logic [31:0] v;
    v = 32'd0;
    case (idx)
      5'd0:  v = 32'd294912000;
      5'd1:  v = 32'd174096719;
      5'd2:  v = 32'd91987925;
      5'd3:  v = 32'd46694507;
      5'd4:  v = 32'd23437865;
      5'd5:  v = 32'd11730358;
      5'd6:  v = 32'd5866610;
      5'd7:  v = 32'd2933484;
      5'd8:  v = 32'd1466765;
      5'd9:  v = 32'd733385;
      5'd10: v = 32'd366693;
      5'd11: v = 32'd183347;
      5'd12: v = 32'd91674;
      5'd13: v = 32'd45837;
      5'd14: v = 32'd22918;
      5'd15: v = 32'd11459;
      5'd16: v = 32'd5730;
      5'd17: v = 32'd2865;
      5'd18: v = 32'd1432;
      5'd19: v = 32'd716;
      5'd20: v = 32'd358;
      5'd21: v = 32'd179;
      5'd22: v = 32'd90;
      5'd23: v = 32'd45;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/aep_if.sv]
// Valid/ready channel interfaces for sample items and results.
// Depends on aep_pkg for the sample width.
`default_nettype none

interface aep_item_if;
  import aep_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [SampleW-1:0] sensor_sample;
  logic signed [15:0] target_elevation;

  modport source (output valid, kind, sensor_sample, target_elevation, input ready);
  modport sink   (input valid, kind, sensor_sample, target_elevation, output ready);
endinterface

interface aep_result_if;
  logic               valid;
  logic               ready;
  logic               bridge_in_a;
  logic               bridge_in_b;
  logic               bridge_enable;
  logic signed [16:0] elevation_now;
  logic [1:0]         motion_mode;
  logic               settled;
  logic               sensor_fault;
  logic               geometry_fault;

  modport source (output valid, bridge_in_a, bridge_in_b, bridge_enable, elevation_now,
                  motion_mode, settled, sensor_fault, geometry_fault, input ready);
  modport sink   (input valid, bridge_in_a, bridge_in_b, bridge_enable, elevation_now,
                  motion_mode, settled, sensor_fault, geometry_fault, output ready);
endinterface

`default_nettype wire

[hw/rtl/aep_alu.sv]
// Bit-serial arithmetic unit: shift-add multiply (32x32) and restoring divide,
// one bit per cycle. Depends on aep_pkg for the request and response types.
`default_nettype none

module aep_alu
  import aep_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire alu_req_t req_i,
  output alu_rsp_t      rsp_o
);

  logic        busy_q, done_q;
  alu_op_e     op_q;
  logic [5:0]  cnt_q;
  logic [31:0] a_q, hi_q, lo_q, quo_q;
  logic [33:0] rem_q, dvs_q;
  logic [63:0] dvd_q;

  logic [32:0] sum_d;
  logic [34:0] trial_d;
  logic        ge_d;
  logic [33:0] rem_d;

  always_comb begin
    sum_d   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : 33'd0);
    trial_d = {rem_q, dvd_q[63]};
    ge_d    = trial_d >= {1'b0, dvs_q};
    rem_d   = ge_d ? 34'(trial_d - {1'b0, dvs_q}) : trial_d[33:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ALU_MUL;
      cnt_q  <= '0;
      a_q    <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      dvd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= req_i.steps;
        a_q    <= req_i.opa;
        hi_q   <= '0;
        lo_q   <= req_i.opb;
        quo_q  <= '0;
        rem_q  <= req_i.rem0;
        dvs_q  <= req_i.dvs;
        dvd_q  <= req_i.dvd;
      end else if (busy_q) begin
        if (op_q == ALU_MUL) begin
          hi_q <= sum_d[32:1];
          lo_q <= {sum_d[0], lo_q[31:1]};
        end else begin
          rem_q <= rem_d;
          quo_q <= {quo_q[30:0], ge_d};
          dvd_q <= {dvd_q[62:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = {hi_q, lo_q};
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

[hw/rtl/actuator_elevation_positioner.sv]
// Top level of the actuator elevation positioner: APB registers, sequencer,
// bit-serial square root, CORDIC arccos and bang-bang motion control.
// Depends on aep_pkg, aep_if (channels) and aep_alu.
//
//  channel   | dir | handshake              | payload
//  item_i    | in  | valid/ready            | kind, sensor_sample, target_elevation
//  result_o  | out | valid/ready            | bridge bits, elevation, mode, flags
//  APB       | in  | psel/penable, pready=1 | 8 registers at 4*index
//
//  One item at a time: six serial multiplies, a (SensorBits+17)-bit and a 30-bit
//  serial divide, a 32-step square root and ArcIters CORDIC rotations; the 30-bit
//  divide is skipped on saturated cosines.
//  The next item is taken while the result waits in the output register.
//  Reset is asynchronous and active low; no clearing pass.
//  A stalled result holds the last stage until result_o.ready.
`default_nettype none

module actuator_elevation_positioner
  import aep_pkg::*;
#(
  parameter int SensorBits = SENSOR_BITS,
  parameter int ArcIters   = ARCCOS_ITERATIONS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  aep_item_if.sink              item_i,
  aep_result_if.source          result_o
);

  localparam int Fs     = (1 << SensorBits) - 1;
  localparam int HalfFs = Fs / 2;
  localparam int PW     = SensorBits + 17;
  localparam int CntW   = $clog2(ArcIters);
  localparam logic [31:0] Z90 = 32'd589824000;
  localparam logic [30:0] One = 31'd1 << 30;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MSPAN, ST_DLEN, ST_MAA, ST_MBB, ST_MLL, ST_MAB, ST_GEOM,
    ST_DCOS, ST_MCC, ST_SQRT, ST_CSET, ST_CORD, ST_FIN, ST_DEC
  } state_e;

  typedef enum logic [1:0] {
    MV_STOP    = 2'd0,
    MV_EXTEND  = 2'd1,
    MV_RETRACT = 2'd2
  } motion_e;

  // configuration
  logic [15:0]        arm_a_q, arm_b_q, base_q, span_q;
  logic signed [15:0] offset_q, lower_q, upper_q;
  logic               enable_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_a_q  <= RstArmA;
      arm_b_q  <= RstArmB;
      base_q   <= RstBase;
      span_q   <= RstSpan;
      offset_q <= RstOffset;
      lower_q  <= RstLower;
      upper_q  <= RstUpper;
      enable_q <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ARM_A:  arm_a_q  <= pwdata[15:0];
        REG_ARM_B:  arm_b_q  <= pwdata[15:0];
        REG_BASE:   base_q   <= pwdata[15:0];
        REG_SPAN:   span_q   <= pwdata[15:0];
        REG_OFFSET: offset_q <= pwdata[15:0];
        REG_LOWER:  lower_q  <= pwdata[15:0];
        REG_UPPER:  upper_q  <= pwdata[15:0];
        REG_ENABLE: enable_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ARM_A:  prdata = {16'd0, arm_a_q};
      REG_ARM_B:  prdata = {16'd0, arm_b_q};
      REG_BASE:   prdata = {16'd0, base_q};
      REG_SPAN:   prdata = {16'd0, span_q};
      REG_OFFSET: prdata = 32'(offset_q);
      REG_LOWER:  prdata = 32'(lower_q);
      REG_UPPER:  prdata = 32'(upper_q);
      REG_ENABLE: prdata = {31'd0, enable_q};
      default:    prdata = '0;
    endcase
  end

  // serial arithmetic unit
  alu_req_t req_q;
  alu_rsp_t rsp;

  aep_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  state_e             state_q;
  motion_e            motion_q;
  logic signed [15:0] held_q;
  logic               kind_q, sfault_q, gfault_q, cneg_q;
  logic signed [15:0] tgt_q;
  logic [16:0]        len_q;
  logic [31:0]        aa_q, bb_q;
  logic [33:0]        ll_q;
  logic [32:0]        den_q;
  logic signed [35:0] num_q;
  logic [30:0]        cmag_q;
  logic [62:0]        sv_q, sr_q, sbit_q;
  logic signed [33:0] x_q, y_q;
  logic signed [31:0] z_q;
  logic [CntW-1:0]    cnt_q;
  logic signed [16:0] elev_q;

  logic               rvalid_q, ra_q, rb_q, ren_q, rset_q, rsf_q, rgf_q;
  logic [1:0]         rmode_q;
  logic signed [16:0] relev_q;

  // combinational helpers
  logic [SensorBits-1:0] smp;
  logic [PW-1:0]         prodh;
  logic [34:0]           mag;
  logic [63:0]           sq_try;
  logic                  sq_ge;
  logic signed [33:0]    dx, dy;
  logic signed [31:0]    atan;
  logic signed [32:0]    zr;
  logic signed [16:0]    ang, angc;
  logic signed [17:0]    elev_w;
  logic signed [16:0]    tgt_x, held_x;
  motion_e               want;
  logic                  go;
  logic                  start_d;

  always_comb begin
    smp    = SensorBits'(item_i.sensor_sample);
    prodh  = PW'(rsp.prod[PW-1:0]) + PW'(HalfFs);
    mag    = num_q[35] ? 35'(-num_q) : 35'(num_q);
    sq_try = {1'b0, sr_q} + {1'b0, sbit_q};
    sq_ge  = {1'b0, sv_q} >= sq_try;
    dx     = y_q >>> cnt_q;
    dy     = x_q >>> cnt_q;
    atan   = signed'(atan_val(5'(cnt_q)));
    zr     = 33'(z_q) + 33'sd32768;
    ang    = 17'(zr >>> 16);
    if (ang < 17'sd0) begin
      angc = 17'sd0;
    end else if (ang > 17'sd18000) begin
      angc = 17'sd18000;
    end else begin
      angc = ang;
    end
    elev_w = 18'sd9000 - 18'(angc) + 18'(offset_q);
    tgt_x  = 17'(tgt_q);
    held_x = 17'(held_q);
    if (tgt_x < elev_q && tgt_q > lower_q) begin
      want = MV_EXTEND;
    end else if (tgt_x > elev_q && tgt_q < upper_q) begin
      want = MV_RETRACT;
    end else begin
      want = MV_STOP;
    end
    go = (motion_q == MV_EXTEND) ? (elev_q > held_x) : (elev_q < held_x);
  end

  always_comb begin
    case (state_q)
      ST_IDLE: start_d = item_i.valid;
      ST_GEOM: start_d = 1'b1;
      ST_MSPAN, ST_DLEN, ST_MAA, ST_MBB, ST_MLL, ST_DCOS: start_d = rsp.done;
      default: start_d = 1'b0;
    endcase
  end

  assign item_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      motion_q <= MV_STOP;
      held_q   <= '0;
      req_q    <= '0;
      kind_q   <= 1'b0;
      sfault_q <= 1'b0;
      gfault_q <= 1'b0;
      cneg_q   <= 1'b0;
      tgt_q    <= '0;
      len_q    <= '0;
      aa_q     <= '0;
      bb_q     <= '0;
      ll_q     <= '0;
      den_q    <= '0;
      num_q    <= '0;
      cmag_q   <= '0;
      sv_q     <= '0;
      sr_q     <= '0;
      sbit_q   <= '0;
      x_q      <= '0;
      y_q      <= '0;
      z_q      <= '0;
      cnt_q    <= '0;
      elev_q   <= '0;
      rvalid_q <= 1'b0;
      ra_q     <= 1'b0;
      rb_q     <= 1'b0;
      ren_q    <= 1'b0;
      rset_q   <= 1'b0;
      rsf_q    <= 1'b0;
      rgf_q    <= 1'b0;
      rmode_q  <= '0;
      relev_q  <= '0;
    end else begin
      req_q.start <= start_d;
      if (rvalid_q && result_o.ready && state_q != ST_DEC) begin
        rvalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (item_i.valid) begin
            kind_q      <= item_i.kind;
            tgt_q       <= item_i.target_elevation;
            sfault_q    <= (smp == '0);
            req_q.op    <= ALU_MUL;
            req_q.opa   <= 32'(span_q);
            req_q.opb   <= 32'(smp);
            req_q.steps <= 6'd32;
            state_q     <= ST_MSPAN;
          end
        end
        ST_MSPAN: begin
          if (rsp.done) begin
            req_q.op    <= ALU_DIV;
            req_q.dvd   <= 64'(prodh) << (64 - PW);
            req_q.dvs   <= 34'(Fs);
            req_q.rem0  <= '0;
            req_q.steps <= 6'(PW);
            state_q     <= ST_DLEN;
          end
        end
        ST_DLEN: begin
          if (rsp.done) begin
            len_q       <= 17'(base_q) + rsp.quo[16:0];
            req_q.op    <= ALU_MUL;
            req_q.opa   <= 32'(arm_a_q);
            req_q.opb   <= 32'(arm_a_q);
            req_q.steps <= 6'd32;
            state_q     <= ST_MAA;
          end
        end
        ST_MAA: begin
          if (rsp.done) begin
            aa_q        <= rsp.prod[31:0];
            req_q.opa   <= 32'(arm_b_q);
            req_q.opb   <= 32'(arm_b_q);
            state_q     <= ST_MBB;
          end
        end
        ST_MBB: begin
          if (rsp.done) begin
            bb_q        <= rsp.prod[31:0];
            req_q.opa   <= 32'(len_q);
            req_q.opb   <= 32'(len_q);
            state_q     <= ST_MLL;
          end
        end
        ST_MLL: begin
          if (rsp.done) begin
            ll_q        <= rsp.prod[33:0];
            req_q.opa   <= 32'(arm_a_q);
            req_q.opb   <= 32'(arm_b_q);
            state_q     <= ST_MAB;
          end
        end
        ST_MAB: begin
          if (rsp.done) begin
            den_q   <= {rsp.prod[31:0], 1'b0};
            num_q   <= 36'(aa_q) + 36'(bb_q) - 36'(ll_q);
            state_q <= ST_GEOM;
          end
        end
        ST_GEOM: begin
          cneg_q <= num_q[35];
          if (den_q == '0 || mag >= 35'(den_q)) begin
            gfault_q    <= (den_q == '0) || (mag > 35'(den_q));
            cmag_q      <= One;
            req_q.op    <= ALU_MUL;
            req_q.opa   <= 32'(One);
            req_q.opb   <= 32'(One);
            req_q.steps <= 6'd32;
            state_q     <= ST_MCC;
          end else begin
            gfault_q    <= 1'b0;
            req_q.op    <= ALU_DIV;
            req_q.dvd   <= '0;
            req_q.dvs   <= 34'(den_q);
            req_q.rem0  <= mag[33:0];
            req_q.steps <= 6'd30;
            state_q     <= ST_DCOS;
          end
        end
        ST_DCOS: begin
          if (rsp.done) begin
            cmag_q      <= rsp.quo[30:0];
            req_q.op    <= ALU_MUL;
            req_q.opa   <= 32'(rsp.quo[30:0]);
            req_q.opb   <= 32'(rsp.quo[30:0]);
            req_q.steps <= 6'd32;
            state_q     <= ST_MCC;
          end
        end
        ST_MCC: begin
          if (rsp.done) begin
            sv_q    <= (63'd1 << 60) - 63'(rsp.prod[60:0]);
            sr_q    <= '0;
            sbit_q  <= 63'd1 << 62;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_ge) begin
            sv_q <= 63'({1'b0, sv_q} - sq_try);
            sr_q <= (sr_q >> 1) + sbit_q;
          end else begin
            sr_q <= sr_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
          if (sbit_q[0]) begin
            state_q <= ST_CSET;
          end
        end
        ST_CSET: begin
          if (cneg_q) begin
            x_q <= 34'(sr_q[31:0]);
            y_q <= 34'(cmag_q);
            z_q <= Z90;
          end else begin
            x_q <= 34'(cmag_q);
            y_q <= 34'(sr_q[31:0]);
            z_q <= '0;
          end
          cnt_q   <= '0;
          state_q <= ST_CORD;
        end
        ST_CORD: begin
          if (y_q > 34'sd0) begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + atan;
          end else begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - atan;
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(ArcIters - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          elev_q  <= elev_w[16:0];
          state_q <= ST_DEC;
        end
        ST_DEC: begin
          if (!rvalid_q || result_o.ready) begin
            automatic motion_e nm = motion_q;
            automatic logic    st = 1'b0;
            if (!kind_q) begin
              if (want != MV_STOP && enable_q) begin
                nm     = want;
                held_q <= tgt_q;
              end else begin
                nm = MV_STOP;
                st = 1'b1;
              end
            end else if (motion_q == MV_EXTEND || motion_q == MV_RETRACT) begin
              if (!go || !enable_q) begin
                nm = MV_STOP;
                st = 1'b1;
              end
            end else begin
              nm = MV_STOP;
            end
            motion_q <= nm;
            rvalid_q <= 1'b1;
            ra_q     <= (nm == MV_EXTEND);
            rb_q     <= (nm == MV_RETRACT);
            ren_q    <= (nm != MV_STOP);
            rmode_q  <= nm;
            rset_q   <= st;
            rsf_q    <= sfault_q;
            rgf_q    <= gfault_q;
            relev_q  <= elev_q;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_o.valid          = rvalid_q;
  assign result_o.bridge_in_a    = ra_q;
  assign result_o.bridge_in_b    = rb_q;
  assign result_o.bridge_enable  = ren_q;
  assign result_o.elevation_now  = relev_q;
  assign result_o.motion_mode    = rmode_q;
  assign result_o.settled        = rset_q;
  assign result_o.sensor_fault   = rsf_q;
  assign result_o.geometry_fault = rgf_q;

  a_rise_from_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rvalid_q) |-> $past(state_q == ST_DEC))
    else $error("result raised outside the decision step");

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == ST_MSPAN || state_q == ST_DLEN || state_q == ST_MAA ||
                  state_q == ST_MBB || state_q == ST_MLL || state_q == ST_MAB ||
                  state_q == ST_DCOS || state_q == ST_MCC))
    else $error("arithmetic unit finished while sequencer was not waiting");

  a_bridge_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> !(ra_q && rb_q) && (ren_q == (ra_q || rb_q)))
    else $error("bridge drive bits inconsistent");

  a_settled_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rvalid_q && rset_q) |-> (rmode_q == MV_STOP))
    else $error("settled reported while moving");

endmodule

`default_nettype wire

[tb/sv/tb_actuator_elevation_positioner.sv]
`timescale 1ns / 100ps
// Self-checking testbench for actuator_elevation_positioner: directed table, then
// random command/tick sequences over several register settings, checked by a predictor.
// Depends on aep_pkg, aep_if and the top-level RTL.
`default_nettype none

module tb_actuator_elevation_positioner;
  import aep_pkg::*;

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam int   CycleLimit = 1000000;
  localparam int   DrainCycles = 400;

  typedef enum logic [1:0] {
    MODE_STOP    = 2'd0,
    MODE_EXTEND  = 2'd1,
    MODE_RETRACT = 2'd2
  } motion_e;

  typedef struct {
    logic               bridge_a;
    logic               bridge_b;
    logic               bridge_en;
    logic signed [16:0] elevation;
    logic [1:0]         mode;
    logic               settled;
    logic               sensor_fault;
    logic               geometry_fault;
  } drive_result_t;

  typedef struct {
    logic    kind;
    int      sample;
    int      target;
    bit      typed;
    motion_e mode;
    bit      settled;
    bit      sensor_fault;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  aep_item_if   item_bus ();
  aep_result_if result_bus ();

  actuator_elevation_positioner dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  // predictor copy of registers and state
  longint  arm_a, arm_b, stroke_base, stroke_span;
  int      elev_offset, lower_limit, upper_limit;
  bit      drive_on;
  motion_e motion;
  int      held_target;

  drive_result_t expected_drive[$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  bit  stall_request = 1'b0;
  int  hold_cycles = 0;
  int  walk_sample = 0;

  longint atan_deg [16] = '{294912000, 174096719, 91987925, 46694507, 23437865,
                            11730358, 5866610, 2933484, 1466765, 733385, 366693,
                            183347, 91674, 45837, 22918, 11459};

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic int elevation_for(int sample, output bit gfault);
    longint len, num, den, c, x, y, z, dx, dy, t, ang;
    longint unsigned mag, q;
    len = stroke_base + (longint'(sample) * stroke_span + 511) / 1023;
    num = arm_a * arm_a + arm_b * arm_b - len * len;
    den = 2 * arm_a * arm_b;
    mag = (num < 0) ? -num : num;
    gfault = 1'b0;
    if (den == 0) begin
      gfault = 1'b1;
      c = (num >= 0) ? (64'sd1 <<< 30) : -(64'sd1 <<< 30);
    end else if (mag >= longint'(den)) begin
      gfault = mag > den;
      c = (num >= 0) ? (64'sd1 <<< 30) : -(64'sd1 <<< 30);
    end else begin
      q = (mag << 30) / longint'(den);
      c = (num < 0) ? -longint'(q) : longint'(q);
    end
    y = longint'(int_sqrt((64'd1 << 60) - c * c));
    x = c;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 64'sd90 * 100 * 65536;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + atan_deg[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_deg[i];
      end
    end
    ang = (z + 32768) >>> 16;
    if (ang < 0) ang = 0;
    if (ang > 18000) ang = 18000;
    return int'(9000 - ang) + elev_offset;
  endfunction

  function automatic drive_result_t predict_drive(logic kind, int sample, int target);
    drive_result_t r;
    bit gfault, settle, go;
    int elev;
    motion_e want;
    settle = 1'b0;
    elev = elevation_for(sample, gfault);
    if (kind == KIND_CMD) begin
      want = MODE_STOP;
      if (target < elev && target > lower_limit) want = MODE_EXTEND;
      else if (target > elev && target < upper_limit) want = MODE_RETRACT;
      if (want != MODE_STOP && drive_on) begin
        motion = want;
        held_target = target;
      end else begin
        motion = MODE_STOP;
        settle = 1'b1;
      end
    end else if (motion != MODE_STOP) begin
      go = (motion == MODE_EXTEND) ? (elev > held_target) : (elev < held_target);
      if (!go || !drive_on) begin
        motion = MODE_STOP;
        settle = 1'b1;
      end
    end
    r.bridge_a       = motion == MODE_EXTEND;
    r.bridge_b       = motion == MODE_RETRACT;
    r.bridge_en      = motion != MODE_STOP;
    r.elevation      = elev[16:0];
    r.mode           = motion;
    r.settled        = settle;
    r.sensor_fault   = sample == 0;
    r.geometry_fault = gfault;
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [15:0] value);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = AddrW'({idx, 2'b00});
    pwdata = {16'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_ARM_A:  arm_a = value;
      REG_ARM_B:  arm_b = value;
      REG_BASE:   stroke_base = value;
      REG_SPAN:   stroke_span = value;
      REG_OFFSET: elev_offset = $signed(value);
      REG_LOWER:  lower_limit = $signed(value);
      REG_UPPER:  upper_limit = $signed(value);
      REG_ENABLE: drive_on = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic write_geometry(int a, int b, int base, int span, int offs);
    write_reg(REG_ARM_A, a[15:0]);
    write_reg(REG_ARM_B, b[15:0]);
    write_reg(REG_BASE, base[15:0]);
    write_reg(REG_SPAN, span[15:0]);
    write_reg(REG_OFFSET, offs[15:0]);
  endtask

  task automatic wait_idle();
    while (expected_drive.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic kind, int sample, int target, bit typed,
                           motion_e mode, bit settle, bit sfault);
    drive_result_t r;
    while (!calm && $urandom_range(0, 99) < 36) begin
      item_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    item_bus.valid            = 1'b1;
    item_bus.kind             = kind;
    item_bus.sensor_sample    = sample[SampleW-1:0];
    item_bus.target_elevation = target[15:0];
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    r = predict_drive(kind, sample, target);
    if (typed) begin
      r.mode = mode;
      r.settled = settle;
      r.sensor_fault = sfault;
    end
    expected_drive.push_back(r);
    @(negedge clk_i);
    item_bus.valid = 1'b0;
  endtask

  task automatic run_random(int count, int tlo, int thi);
    int sample, target;
    logic kind;
    for (int k = 0; k < count; k++) begin
      kind = ($urandom_range(0, 5) == 0) ? KIND_CMD : KIND_TICK;
      if ($urandom_range(0, 99) < 15) begin
        walk_sample = $urandom_range(0, 1023);
      end else begin
        walk_sample = walk_sample + int'($urandom_range(0, 80)) - 40;
        if (walk_sample < 0) walk_sample = 0;
        if (walk_sample > 1023) walk_sample = 1023;
      end
      sample = walk_sample;
      if ($urandom_range(0, 9) == 0) target = int'($urandom_range(0, 36000)) - 18000;
      else target = int'($urandom_range(0, thi - tlo)) + tlo;
      send_item(kind, sample, target, 1'b0, MODE_STOP, 1'b0, 1'b0);
    end
  endtask

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    drive_result_t e;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (expected_drive.size() == 0) begin
        $error("result transaction with nothing expected");
        error_count++;
      end else begin
        e = expected_drive.pop_front();
        check_field("bridge_in_a", e.bridge_a, result_bus.bridge_in_a);
        check_field("bridge_in_b", e.bridge_b, result_bus.bridge_in_b);
        check_field("bridge_enable", e.bridge_en, result_bus.bridge_enable);
        check_field("elevation_now", e.elevation, result_bus.elevation_now);
        check_field("motion_mode", e.mode, result_bus.motion_mode);
        check_field("settled", e.settled, result_bus.settled);
        check_field("sensor_fault", e.sensor_fault, result_bus.sensor_fault);
        check_field("geometry_fault", e.geometry_fault, result_bus.geometry_fault);
      end
    end
  end

  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_cycles = 3000;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        result_bus.ready = 1'b0;
      end else begin
        result_bus.ready = calm || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  initial begin
    stim_row_t rows [14];
    item_bus.valid = 1'b0;
    item_bus.kind = KIND_TICK;
    item_bus.sensor_sample = '0;
    item_bus.target_elevation = '0;
    arm_a = RstArmA; arm_b = RstArmB; stroke_base = RstBase; stroke_span = RstSpan;
    elev_offset = $signed(RstOffset);
    lower_limit = $signed(RstLower);
    upper_limit = $signed(RstUpper);
    drive_on = 1'b1;
    motion = MODE_STOP;
    held_target = 0;
    rows = '{
      '{KIND_TICK, 0,    0,      1, MODE_STOP,    0, 1},
      '{KIND_CMD,  0,    18000,  1, MODE_STOP,    1, 1},
      '{KIND_CMD,  1023, -18000, 1, MODE_STOP,    1, 0},
      '{KIND_CMD,  0,    2000,   1, MODE_EXTEND,  0, 1},
      '{KIND_TICK, 0,    0,      1, MODE_EXTEND,  0, 1},
      '{KIND_TICK, 512,  0,      1, MODE_STOP,    1, 0},
      '{KIND_CMD,  1023, 5000,   1, MODE_RETRACT, 0, 0},
      '{KIND_TICK, 1023, -1,     1, MODE_RETRACT, 0, 0},
      '{KIND_CMD,  1023, 7999,   1, MODE_RETRACT, 0, 0},
      '{KIND_TICK, 0,    0,      1, MODE_RETRACT, 0, 1},
      '{KIND_CMD,  0,    1000,   1, MODE_STOP,    1, 1},
      '{KIND_TICK, 1023, 0,      1, MODE_STOP,    0, 0},
      '{KIND_CMD,  341,  1500,   0, MODE_STOP,    0, 0},
      '{KIND_TICK, 682,  -21846, 0, MODE_STOP,    0, 0}
    };
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i])
      send_item(rows[i].kind, rows[i].sample, rows[i].target, rows[i].typed,
                rows[i].mode, rows[i].settled, rows[i].sensor_fault);
    run_random(60, -1000, 9000);

    // short arm against a long one: the cosine saturates
    wait_idle();
    write_geometry(1, 65535, 0, 65535, -18000);
    write_reg(REG_LOWER, 16'(-18000));
    write_reg(REG_UPPER, 16'(18000));
    stall_request = 1'b1;
    run_random(80, -18000, 18000);

    wait_idle();
    write_geometry(65535, 65535, 65535, 0, 18000);
    write_reg(REG_LOWER, 16'(18000));
    write_reg(REG_UPPER, 16'(-18000));
    write_reg(REG_ENABLE, 16'd0);
    run_random(40, -18000, 18000);

    // start a move, then take the drive away under it
    wait_idle();
    write_geometry(4000, 4000, 3600, 2200, int'($urandom_range(0, 2000)) - 1000);
    write_reg(REG_LOWER, 16'(-18000));
    write_reg(REG_UPPER, 16'(18000));
    write_reg(REG_ENABLE, 16'd1);
    send_item(KIND_CMD, 0, -17000, 0, MODE_STOP, 0, 0);
    wait_idle();
    write_reg(REG_ENABLE, 16'd0);
    send_item(KIND_TICK, 0, 0, 1, MODE_STOP, 1, 1);
    send_item(KIND_CMD, 0, -17000, 1, MODE_STOP, 1, 1);
    run_random(30, -1000, 9000);

    wait_idle();
    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_LOWER, 16'd1000);
    write_reg(REG_UPPER, 16'd8000);
    calm = 1'b1;
    run_random(60, -1000, 9000);
    calm = 1'b0;
    run_random(80, -1000, 9000);

    while (expected_drive.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/aep_pkg.sv
hw/rtl/aep_if.sv
hw/rtl/aep_alu.sv
hw/rtl/actuator_elevation_positioner.sv
tb/sv/tb_actuator_elevation_positioner.sv
